>>> hw/rtl/lttd_pkg.sv
// Shared types, codes and a helper function of the line-table delta decoder.
`timescale 1ns / 1ps

package lttd_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_QUERY_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_BASE_ADDRESS  = 2'd1;
   localparam logic [1:0] CSR_ENTRY_COUNT   = 2'd2;

   // Each ULEB128 byte carries seven payload bits.
   localparam logic [5:0] SHIFT_STEP = 6'd7;
   // Shift of the tenth byte of a value; a value always ends there.
   localparam logic [5:0] SHIFT_LAST = 6'd63;

   typedef enum logic [1:0] {
      ST_HIT      = 2'd0,
      ST_NO_ENTRY = 2'd1,
      ST_BAD_LINE = 2'd2,
      ST_BAD_FILE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FLD_ADDR = 2'd0,
      FLD_FILE = 2'd1,
      FLD_LINE = 2'd2
   } field_type;

   typedef struct packed {
      logic [63:0] query_address;
      logic [63:0] base_address;
      logic [31:0] entry_count;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] file_index;
      logic [31:0] line_number;
   } result_type;

   // Zigzag decode: even codes are non-negative, odd codes negative.
   function automatic logic [63:0] zigzag_decode(input logic [63:0] code);
      return {1'b0, code[63:1]} ^ {64{code[0]}};
   endfunction

endpackage

>>> hw/rtl/lttd_csr.sv
// Configuration registers of the line-table delta decoder.
`timescale 1ns / 1ps

module lttd_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [63:0]           csr_wdata,
   output lttd_pkg::cfg_type     cfg
);

   lttd_pkg::cfg_type cfg_ff;
   lttd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            lttd_pkg::CSR_QUERY_ADDRESS: cfg_in.query_address = csr_wdata;
            lttd_pkg::CSR_BASE_ADDRESS:  cfg_in.base_address  = csr_wdata;
            lttd_pkg::CSR_ENTRY_COUNT:   cfg_in.entry_count   = csr_wdata[31:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/lttd_decode.sv
// Byte decoder: ULEB128 gathering, delta accumulation, entry judging and result.
`timescale 1ns / 1ps

module lttd_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               stream_byte,
   input  logic                     first_byte,
   input  logic                     last_byte,
   input  lttd_pkg::cfg_type        cfg,
   output logic                     emit,
   output lttd_pkg::result_type     result
);

   logic [63:0]         cur_addr_ff, cur_addr_in;
   logic [63:0]         file_acc_ff, file_acc_in;
   logic [63:0]         line_acc_ff, line_acc_in;
   logic [63:0]         kept_file_ff, kept_file_in;
   logic [63:0]         kept_line_ff, kept_line_in;
   logic                found_ff, found_in;
   logic [63:0]         partial_ff, partial_in;
   logic [5:0]          shift_ff, shift_in;
   lttd_pkg::field_type pos_ff, pos_in;
   logic [31:0]         seen_ff, seen_in;
   logic                finished_ff, finished_in;

   // State as seen after an optional first-byte clear.
   logic [63:0]         cur_addr_s, file_acc_s, line_acc_s, kept_file_s, kept_line_s;
   logic [63:0]         partial_s;
   logic [5:0]          shift_s;
   lttd_pkg::field_type pos_s;
   logic [31:0]         seen_s;
   logic                found_s, finished_s;

   logic [63:0] gathered;
   logic [63:0] zz_value;
   logic        value_done;
   logic        apply_en;
   logic        judge_en;
   logic [31:0] seen_next;
   logic        stop;

   always_comb begin
      if (first_byte) begin
         cur_addr_s  = cfg.base_address;
         file_acc_s  = '0;
         line_acc_s  = '0;
         kept_file_s = '1;
         kept_line_s = '0;
         found_s     = 1'b0;
         partial_s   = '0;
         shift_s     = '0;
         pos_s       = lttd_pkg::FLD_ADDR;
         seen_s      = '0;
         finished_s  = 1'b0;
      end else begin
         cur_addr_s  = cur_addr_ff;
         file_acc_s  = file_acc_ff;
         line_acc_s  = line_acc_ff;
         kept_file_s = kept_file_ff;
         kept_line_s = kept_line_ff;
         found_s     = found_ff;
         partial_s   = partial_ff;
         shift_s     = shift_ff;
         pos_s       = pos_ff;
         seen_s      = seen_ff;
         finished_s  = finished_ff;
      end
   end

   assign gathered   = partial_s | ({57'd0, stream_byte[6:0]} << shift_s);
   assign zz_value   = lttd_pkg::zigzag_decode(gathered);
   assign value_done = !stream_byte[7] || (shift_s == lttd_pkg::SHIFT_LAST);
   // A cut stream folds the partial value into its field and judges the entry at once.
   assign apply_en   = value_done || last_byte;
   assign judge_en   = (value_done && pos_s == lttd_pkg::FLD_LINE) || last_byte;
   assign seen_next  = seen_s + 32'd1;

   always_comb begin
      cur_addr_in  = cur_addr_s;
      file_acc_in  = file_acc_s;
      line_acc_in  = line_acc_s;
      kept_file_in = kept_file_s;
      kept_line_in = kept_line_s;
      found_in     = found_s;
      partial_in   = partial_s;
      shift_in     = shift_s;
      pos_in       = pos_s;
      seen_in      = seen_s;
      finished_in  = finished_s;
      stop         = 1'b0;
      emit         = 1'b0;

      if (finished_s) begin
         emit = 1'b0;
      end else if (seen_s >= cfg.entry_count) begin
         emit        = 1'b1;
         finished_in = 1'b1;
      end else begin
         if (apply_en) begin
            case (pos_s)
               lttd_pkg::FLD_ADDR: cur_addr_in = cur_addr_s + gathered;
               lttd_pkg::FLD_FILE: file_acc_in = file_acc_s + zz_value;
               lttd_pkg::FLD_LINE: line_acc_in = line_acc_s + zz_value;
               default:            cur_addr_in = cur_addr_s;
            endcase
         end

         if (value_done) begin
            partial_in = '0;
            shift_in   = '0;
            case (pos_s)
               lttd_pkg::FLD_ADDR: pos_in = lttd_pkg::FLD_FILE;
               lttd_pkg::FLD_FILE: pos_in = lttd_pkg::FLD_LINE;
               default:            pos_in = lttd_pkg::FLD_ADDR;
            endcase
         end else begin
            partial_in = gathered;
            shift_in   = shift_s + lttd_pkg::SHIFT_STEP;
         end

         if (judge_en) begin
            if (cur_addr_in > cfg.query_address) begin
               stop = 1'b1;
            end else begin
               kept_file_in = file_acc_in;
               kept_line_in = line_acc_in;
               found_in     = 1'b1;
               seen_in      = seen_next;
               stop         = (seen_next >= cfg.entry_count);
            end
            if (last_byte) begin
               partial_in = '0;
               shift_in   = '0;
               pos_in     = lttd_pkg::FLD_ADDR;
            end
         end

         emit        = judge_en && (stop || last_byte);
         finished_in = emit;
      end
   end

   // The result reflects the best entry as it stands after this byte.
   always_comb begin
      result = '0;
      if (!found_in) begin
         result.status = lttd_pkg::ST_NO_ENTRY;
      end else if (kept_line_in[63] || kept_line_in == 64'd0) begin
         result.status = lttd_pkg::ST_BAD_LINE;
      end else if (kept_file_in[63]) begin
         result.status = lttd_pkg::ST_BAD_FILE;
      end else begin
         result.status      = lttd_pkg::ST_HIT;
         result.file_index  = kept_file_in[31:0];
         result.line_number = kept_line_in[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_addr_ff  <= '0;
         file_acc_ff  <= '0;
         line_acc_ff  <= '0;
         kept_file_ff <= '1;
         kept_line_ff <= '0;
         found_ff     <= 1'b0;
         partial_ff   <= '0;
         shift_ff     <= '0;
         pos_ff       <= lttd_pkg::FLD_ADDR;
         seen_ff      <= '0;
         finished_ff  <= 1'b0;
      end else if (step) begin
         cur_addr_ff  <= cur_addr_in;
         file_acc_ff  <= file_acc_in;
         line_acc_ff  <= line_acc_in;
         kept_file_ff <= kept_file_in;
         kept_line_ff <= kept_line_in;
         found_ff     <= found_in;
         partial_ff   <= partial_in;
         shift_ff     <= shift_in;
         pos_ff       <= pos_in;
         seen_ff      <= seen_in;
         finished_ff  <= finished_in;
      end
   end

endmodule

>>> hw/rtl/line_table_delta_decoder_core.sv
// Top level of the line-table delta decoder: request and response registers.
`timescale 1ns / 1ps

// Decodes a line-table stream at one byte per cycle unless stalled: every
// request is one stream byte and requests may arrive back to back. An
// accepted byte sits in the request register and is decoded when the decoder
// steps, which updates the entry state and, when decoding stops, loads the
// single response into the response register, from which it is presented.
// Requests stall only while a byte is held and a response waits in the
// response register under rsp_stall. The cycle time is
// set by the per-byte decode step (a variable shift and a 64-bit add followed
// by a 64-bit compare against the query address). Configuration is to be
// written only while no table is being decoded; the block does not enforce it.
module line_table_delta_decoder_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_file_index,
   output logic [31:0] rsp_line_number,

   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   lttd_pkg::cfg_type    cfg;
   lttd_pkg::result_type dec_result;
   logic                 dec_emit;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       in_last_ff;

   logic                 out_valid_ff, out_valid_in;
   lttd_pkg::result_type out_result_ff;

   logic advance;
   logic step;
   logic accept;

   lttd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lttd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .stream_byte (in_byte_ff),
      .first_byte  (in_first_ff),
      .last_byte   (in_last_ff),
      .cfg         (cfg),
      .emit        (dec_emit),
      .result      (dec_result)
   );

   // The held byte moves on whenever the response register is free or being drained.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (step && dec_emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_stream_byte;
         in_first_ff <= req_first_byte;
         in_last_ff  <= req_last_byte;
      end
      if (step && dec_emit) begin
         out_result_ff <= dec_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_result_ff.status;
   assign rsp_file_index  = out_result_ff.file_index;
   assign rsp_line_number = out_result_ff.line_number;

   // A response produced by the decoder must land in the response register.
   assert property (@(posedge clock) disable iff (reset)
      step && dec_emit |=> out_valid_ff)
      else $error("decoder response was dropped");

   // An accepted request must be held for the decoder.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted request was lost");

   // The decoder only steps while the response register can take a result.
   assert property (@(posedge clock) disable iff (reset)
      step |-> !(out_valid_ff && rsp_stall))
      else $error("decoder stepped into a stalled response register");

endmodule
